// ===== rtl/tctp_pkg.sv =====
// Shared types and operation codes of the typed cooldown timer pool.
`default_nettype none
package tctp_pkg;

  localparam int KIND_W = 3;
  localparam int TYPE_W = 8;
  localparam int TIME_W = 16;
  localparam int IDX_W  = 4;

  localparam logic [KIND_W-1:0] KIND_ADD   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CHECK = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FIND  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RESET = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TICK  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd5;

  // Payload of one slot, held in the slot memory
  typedef struct packed {
    logic [TYPE_W-1:0] typ;
    logic [TIME_W-1:0] dur;
    logic [TIME_W-1:0] ela;
    logic              rec;
  } slot_ent_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // op fields latched, accumulators cleared
    logic scan;   // a slot's data sits in the read register
    logic step;   // commit the current slot
    logic rd_en;  // fetch the slot at rd_addr
    logic fin;    // commit the op and present its closing result
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic emit_need;  // current slot produces a completion transfer
    logic out_free;   // output register can take a result this cycle
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/tctp_in_if.sv =====
// Input channel of the timer pool: operation items.
`default_nettype none
interface tctp_in_if;
  logic                        valid;
  logic                        ready;
  logic [tctp_pkg::KIND_W-1:0] kind;
  logic [tctp_pkg::TYPE_W-1:0] event_type;
  logic [tctp_pkg::TIME_W-1:0] duration;
  logic                        recycle;

  modport source (output valid, kind, event_type, duration, recycle, input ready);
  modport sink (input valid, kind, event_type, duration, recycle, output ready);
endinterface
`default_nettype wire

// ===== rtl/tctp_out_if.sv =====
// Output channel of the timer pool: result items.
`default_nettype none
interface tctp_out_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [tctp_pkg::IDX_W-1:0]  slot_index;
  logic [tctp_pkg::TYPE_W-1:0] done_type;
  logic                        last;

  modport source (output valid, hit, slot_index, done_type, last, input ready);
  modport sink (input valid, hit, slot_index, done_type, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/tctp_ctrl.sv =====
// Controller of the timer pool: op sequencing and the slot walk counter.
`default_nettype none
module tctp_ctrl #(
  parameter int SLOTS = 16,
  parameter int SW    = $clog2(SLOTS)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                idle,
  input  tctp_pkg::dp_sts_t   sts,
  output tctp_pkg::ctrl_cmd_t cmd,
  output logic [SW-1:0]       idx,
  output logic [SW-1:0]       rd_addr
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam logic [SW-1:0] IDX_LAST = SW'(SLOTS - 1);

  logic [1:0] state;
  logic [1:0] state_next;
  logic       at_last;

  assign at_last = (idx == IDX_LAST);
  assign idle    = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    rd_addr    = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          cmd.rd_en  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        // a completing slot holds the walk until the output register frees
        cmd.step = !sts.emit_need || sts.out_free;
        if (cmd.step) begin
          if (at_last) begin
            state_next = ST_FIN;
          end else begin
            cmd.rd_en = 1'b1;
            rd_addr   = idx + SW'(1);
          end
        end
      end
      ST_FIN: begin
        cmd.fin = sts.out_free;
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        idx <= '0;
      end else if (cmd.step && !at_last) begin
        idx <= idx + SW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tctp_dpath.sv =====
// Datapath of the timer pool: slot store, per-slot update, search state, result register.
`default_nettype none
module tctp_dpath #(
  parameter int SLOTS = 16,
  parameter int SW    = $clog2(SLOTS)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tctp_pkg::ctrl_cmd_t         cmd,
  input  logic [SW-1:0]               idx,
  input  logic [SW-1:0]               rd_addr,
  output tctp_pkg::dp_sts_t           sts,
  input  logic [tctp_pkg::KIND_W-1:0] op_kind,
  input  logic [tctp_pkg::TYPE_W-1:0] op_type,
  input  logic [tctp_pkg::TIME_W-1:0] op_dur,
  input  logic                        op_rec,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output logic                        rsp_hit,
  output logic [tctp_pkg::IDX_W-1:0]  rsp_index,
  output logic [tctp_pkg::TYPE_W-1:0] rsp_type,
  output logic                        rsp_last
);

  tctp_pkg::slot_ent_t mem [SLOTS];
  tctp_pkg::slot_ent_t rdata;

  logic [tctp_pkg::KIND_W-1:0] kind_r;
  logic [tctp_pkg::TYPE_W-1:0] typ_r;
  logic [tctp_pkg::TIME_W-1:0] dur_r;
  logic                        rec_r;

  logic [SLOTS-1:0] used;
  logic [SLOTS-1:0] cmpl;

  logic          found;
  logic          found_cmp;
  logic [SW-1:0] found_idx;
  logic          free_found;
  logic [SW-1:0] free_idx;
  logic          any_match;

  logic cur_used;
  logic cur_cmpl;
  logic match;
  logic live;
  logic expire_zero;
  logic expire;
  logic is_free;
  logic add_ok;

  logic                we;
  logic [SW-1:0]       wa;
  tctp_pkg::slot_ent_t wd;
  logic                wr_scan;

  logic                        fin_hit;
  logic [SW-1:0]               fin_idx;
  logic [SW+tctp_pkg::IDX_W-1:0] idx_ext;
  logic [SW+tctp_pkg::IDX_W-1:0] fin_ext;
  logic                        emit_do;
  logic                        out_free;

  assign cur_used    = used[idx];
  assign cur_cmpl    = cmpl[idx];
  assign match       = cur_used && (rdata.typ == typ_r);
  assign live        = cur_used && (rdata.typ != '0);
  assign expire_zero = live && cur_cmpl && !rdata.rec;
  assign expire      = live && !expire_zero && (rdata.ela >= rdata.dur);
  assign is_free     = !cur_used || (rdata.typ == '0);
  assign add_ok      = !(found && !found_cmp) && free_found;

  assign out_free      = !rsp_valid || rsp_ready;
  assign sts.out_free  = out_free;
  // only looked at while walking; kept free of the command lines
  assign sts.emit_need = (kind_r == tctp_pkg::KIND_TICK) && expire;
  assign emit_do       = cmd.step && cmd.scan && sts.emit_need;

  // slot write-back during the walk, and the new slot written by an add at the close
  always_comb begin
    wr_scan = 1'b0;
    wd      = rdata;
    unique case (kind_r)
      tctp_pkg::KIND_RESET: begin
        wr_scan = match;
        wd.ela  = '0;
      end
      tctp_pkg::KIND_TICK: begin
        if (expire) begin
          wr_scan = 1'b1;
          wd.ela  = '0;
        end else if (live && !cur_cmpl && !expire_zero) begin
          wr_scan = 1'b1;
          wd.ela  = rdata.ela + tctp_pkg::TIME_W'(1);
        end
      end
      default: begin
        wr_scan = 1'b0;
      end
    endcase
    if (cmd.fin) begin
      wd.typ = typ_r;
      wd.dur = dur_r;
      wd.ela = '0;
      wd.rec = rec_r;
    end
  end

  assign we = (cmd.step && wr_scan) || (cmd.fin && (kind_r == tctp_pkg::KIND_ADD) && add_ok);
  assign wa = cmd.fin ? free_idx : idx;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= op_kind;
      typ_r  <= op_type;
      dur_r  <= op_dur;
      rec_r  <= op_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= '0;
      cmpl       <= '0;
      found      <= 1'b0;
      found_cmp  <= 1'b0;
      found_idx  <= '0;
      free_found <= 1'b0;
      free_idx   <= '0;
      any_match  <= 1'b0;
    end else if (cmd.load) begin
      found      <= 1'b0;
      found_cmp  <= 1'b0;
      found_idx  <= '0;
      free_found <= 1'b0;
      free_idx   <= '0;
      any_match  <= 1'b0;
    end else if (cmd.step) begin
      if (match && !found) begin
        found     <= 1'b1;
        found_cmp <= cur_cmpl;
        found_idx <= idx;
      end
      if ((kind_r == tctp_pkg::KIND_ADD) && is_free && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= idx;
      end
      if ((kind_r == tctp_pkg::KIND_RESET) && match) begin
        cmpl[idx] <= 1'b0;
        any_match <= 1'b1;
      end
      if (kind_r == tctp_pkg::KIND_TICK) begin
        if (expire_zero) begin
          used[idx] <= 1'b0;
          cmpl[idx] <= 1'b0;
        end else if (expire) begin
          cmpl[idx] <= 1'b1;
        end
      end
    end else if (cmd.fin) begin
      if ((kind_r == tctp_pkg::KIND_ADD) && add_ok) begin
        used[free_idx] <= 1'b1;
        cmpl[free_idx] <= 1'b0;
      end
      if (kind_r == tctp_pkg::KIND_CLEAR) begin
        used <= '0;
        cmpl <= '0;
      end
    end
  end

  // closing result of each op
  always_comb begin
    fin_hit = 1'b0;
    fin_idx = '0;
    unique case (kind_r)
      tctp_pkg::KIND_ADD: begin
        fin_hit = add_ok;
        fin_idx = add_ok ? free_idx : '0;
      end
      tctp_pkg::KIND_CHECK: begin
        fin_hit = found && !found_cmp;
      end
      tctp_pkg::KIND_FIND: begin
        fin_hit = found;
        fin_idx = found_idx;
      end
      tctp_pkg::KIND_RESET: begin
        fin_hit = any_match;
      end
      default: begin
        fin_hit = 1'b0;
      end
    endcase
  end

  // slot numbers beyond four bits report their low bits
  assign idx_ext = {{tctp_pkg::IDX_W{1'b0}}, idx};
  assign fin_ext = {{tctp_pkg::IDX_W{1'b0}}, fin_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit_do || cmd.fin) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_do) begin
      rsp_hit   <= 1'b1;
      rsp_index <= idx_ext[tctp_pkg::IDX_W-1:0];
      rsp_type  <= rdata.typ;
      rsp_last  <= 1'b0;
    end else if (cmd.fin) begin
      rsp_hit   <= fin_hit;
      rsp_index <= fin_ext[tctp_pkg::IDX_W-1:0];
      rsp_type  <= '0;
      rsp_last  <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/typed_cooldown_timer_pool_unit.sv =====
// Top level of the typed cooldown timer pool.
//
//   channel | dir | payload                                    | transfer
//   req     | in  | kind, event_type, duration, recycle        | valid & ready
//   rsp     | out | hit, slot_index, done_type, last           | valid & ready
//
// Every op walks the slot memory one slot a cycle through the single slot memory
// read port: a fetch of the first slot, a step per slot, then a closing step. A
// tick completion waits in its slot step while the output register is full, and
// the closing step waits likewise. req is ready only between ops.
// Reset clears the used and complete flags; the slot memory needs no sweep.
`default_nettype none
module typed_cooldown_timer_pool_unit #(
  parameter int SLOTS = 16
) (
  input logic        clk,
  input logic        rst,
  tctp_in_if.sink    req,
  tctp_out_if.source rsp
);

  localparam int SW = $clog2(SLOTS);

  tctp_pkg::ctrl_cmd_t cmd;
  tctp_pkg::dp_sts_t   sts;
  logic [SW-1:0]       idx;
  logic [SW-1:0]       rd_addr;
  logic                idle;

  assign req.ready = idle;

  tctp_ctrl #(
    .SLOTS (SLOTS),
    .SW    (SW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .idle      (idle),
    .sts       (sts),
    .cmd       (cmd),
    .idx       (idx),
    .rd_addr   (rd_addr)
  );

  tctp_dpath #(
    .SLOTS (SLOTS),
    .SW    (SW)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .idx       (idx),
    .rd_addr   (rd_addr),
    .sts       (sts),
    .op_kind   (req.kind),
    .op_type   (req.event_type),
    .op_dur    (req.duration),
    .op_rec    (req.recycle),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_hit   (rsp.hit),
    .rsp_index (rsp.slot_index),
    .rsp_type  (rsp.done_type),
    .rsp_last  (rsp.last)
  );

endmodule
`default_nettype wire
